### hdl/sawh_pkg.sv
`default_nettype none

package sawh_pkg;

    // Fixed by the 17-bit offset and size fields
    localparam int OFS_W        = 17;
    localparam int BUF_BYTES    = 65536;
    localparam int HEADER_BYTES = 16;
    localparam int ALIGN_CAP    = 7;
    // Padding never exceeds the header size plus one alignment unit
    localparam int PAD_W        = $clog2(HEADER_BYTES + 128);

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_FREE_ALL = 2'd2,
        OP_RESIZE   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_NOSPACE = 3'd1,
        STS_DOUBLE  = 3'd2,
        STS_ORDER   = 3'd3,
        STS_BOUNDS  = 3'd4,
        STS_FULL    = 3'd5
    } t_status;

    // Configuration register indexes
    typedef enum logic {
        CFG_BASE_LOW = 1'b0,
        CFG_BUF_LEN  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_opcode          opcode;
        logic             has_pointer;
        logic [OFS_W-1:0] pointer_offset;
        logic [OFS_W-1:0] request_size;
        logic [OFS_W-1:0] old_size;
        logic [3:0]       align_log2;
    } t_in;

    typedef struct packed {
        t_status          status;
        logic             result_valid;
        logic [OFS_W-1:0] result_offset;
        logic [OFS_W-1:0] copy_length;
    } t_out;

    // One header record: top before the allocation and its data offset
    typedef struct packed {
        logic [OFS_W-1:0] prev;
        logic [OFS_W-1:0] data;
    } t_hdr;

    // Padding from a misaligned address up to an aligned start that leaves
    // room for a header
    function automatic logic [PAD_W-1:0] sawh_pad(input logic [6:0] addr,
                                                  input logic [2:0] lg);
        logic [PAD_W-1:0] align;
        logic [PAD_W-1:0] amask;
        logic [PAD_W-1:0] modv;
        logic [PAD_W-1:0] pad;
        logic [PAD_W-1:0] need;
        logic [PAD_W-1:0] units;
        align = PAD_W'(1) << lg;
        amask = align - PAD_W'(1);
        modv  = PAD_W'(addr) & amask;
        pad   = (modv != '0) ? align - modv : '0;
        need  = '0;
        units = '0;
        if (pad < PAD_W'(HEADER_BYTES)) begin
            need  = PAD_W'(HEADER_BYTES) - pad;
            units = (need >> lg) + PAD_W'(|(need & amask));
            pad   = pad + (units << lg);
        end
        return pad;
    endfunction

endpackage

`default_nettype wire

### hdl/sawh_hdr_stack.sv
`default_nettype none

// Header LIFO storage: one write port, one registered read port
module sawh_hdr_stack
    import sawh_pkg::*;
#(
    parameter int Depth = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(Depth)-1:0] i_wr_addr,
    input  wire t_hdr                     i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(Depth)-1:0] i_rd_addr,
    output t_hdr                          o_rd_data
);

    t_hdr r_mem [Depth];
    t_hdr r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hdl/stack_allocator_with_headers.sv
`default_nettype none

// A result is registered in the execute state after its item is accepted,
// later while the previous result still waits for the receiver.
// One item at a time: input is ready only when idle; the header stack read
// feeds the update step, which writes the stack and the top pointers back.
// Reset (synchronous, active low): top, last start and header count clear,
// base low bits go to 0 and buffer length to 65536; header memory is not cleared.
module stack_allocator_with_headers
    import sawh_pkg::*;
#(
    parameter int MAX_LIVE = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in              i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out                  o_out,
    input  wire logic             i_cfg_we,
    input  wire t_cfg_index       i_cfg_index,
    input  wire logic [OFS_W-1:0] i_cfg_data
);

    localparam int AddrW = $clog2(MAX_LIVE);
    localparam int CntW  = $clog2(MAX_LIVE + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state           r_state, n_state;
    t_in              r_cmd;
    logic [PAD_W-1:0] r_pad;
    logic [OFS_W-1:0] r_top, n_top;
    logic [OFS_W-1:0] r_last, n_last;
    logic [CntW-1:0]  r_count, n_count;
    logic [6:0]       r_base;
    logic [OFS_W-1:0] r_len;
    logic             r_out_valid;
    t_out             r_out, n_out;

    logic             in_fire;
    logic             exec_go;
    logic [2:0]       lg_c;
    logic [6:0]       mis_addr;
    logic [PAD_W-1:0] pad_c;
    t_hdr             rd_hdr;
    t_hdr             wr_hdr;
    logic             push;

    logic [OFS_W-1:0] len;
    logic [OFS_W+1:0] alloc_end;
    logic             alloc_fit;
    logic             full;
    logic [OFS_W-1:0] data_off;
    logic [OFS_W:0]   inplace_end;
    logic             inplace_fit;
    logic             ptr_hit;
    logic             ptr_oob;
    logic             ptr_dbl;
    logic [OFS_W-1:0] min_sz;
    logic             do_alloc;
    logic             do_free;
    logic             copy_en;

    // Handshake
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign exec_go     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Padding for the current top, worked out while the stack is read
    assign lg_c     = (i_in.align_log2 > 4'(ALIGN_CAP)) ? 3'(ALIGN_CAP) : i_in.align_log2[2:0];
    assign mis_addr = r_base + r_top[6:0];
    assign pad_c    = sawh_pad(mis_addr, lg_c);

    sawh_hdr_stack #(
        .Depth(MAX_LIVE)
    ) u_hdr_stack (
        .i_clk    (i_clk),
        .i_wr_en  (push),
        .i_wr_addr(r_count[AddrW-1:0]),
        .i_wr_data(wr_hdr),
        .i_rd_en  (in_fire),
        .i_rd_addr(r_count[AddrW-1:0] - AddrW'(1)),
        .o_rd_data(rd_hdr)
    );

    // Bounds and sums shared by the allocate, free and resize opcodes
    assign len         = (r_len > OFS_W'(BUF_BYTES)) ? OFS_W'(BUF_BYTES) : r_len;
    assign alloc_end   = {2'b00, r_top} + (OFS_W+2)'(r_pad) + {2'b00, r_cmd.request_size};
    assign alloc_fit   = alloc_end <= {2'b00, len};
    assign full        = r_count >= CntW'(MAX_LIVE);
    assign data_off    = r_top + OFS_W'(r_pad);
    assign inplace_end = {1'b0, r_last} + {1'b0, r_cmd.request_size};
    assign inplace_fit = inplace_end <= {1'b0, len};
    assign ptr_hit     = r_cmd.pointer_offset == r_last;
    assign ptr_oob     = r_cmd.pointer_offset > len;
    assign ptr_dbl     = r_cmd.pointer_offset >= r_top;
    assign min_sz      = (r_cmd.old_size < r_cmd.request_size) ? r_cmd.old_size
                                                               : r_cmd.request_size;
    assign wr_hdr      = '{prev: r_top, data: data_off};

    // Update step: decode, then the shared allocate and free paths
    always_comb begin
        n_top    = r_top;
        n_last   = r_last;
        n_count  = r_count;
        n_out    = '0;
        push     = 1'b0;
        do_alloc = 1'b0;
        do_free  = 1'b0;
        copy_en  = 1'b0;

        unique case (r_cmd.opcode)
            OP_ALLOC: begin
                do_alloc = 1'b1;
            end
            OP_FREE: begin
                do_free = r_cmd.has_pointer;
            end
            OP_FREE_ALL: begin
                n_top   = '0;
                n_last  = '0;
                n_count = '0;
            end
            OP_RESIZE: begin
                if (!r_cmd.has_pointer) begin
                    do_alloc = 1'b1;
                end else if (ptr_hit) begin
                    // in place for the latest allocation
                    if (r_cmd.old_size != r_cmd.request_size && !inplace_fit) begin
                        n_out.status = STS_NOSPACE;
                    end else begin
                        if (r_cmd.old_size != r_cmd.request_size) begin
                            n_top = inplace_end[OFS_W-1:0];
                        end
                        n_out.result_valid  = 1'b1;
                        n_out.result_offset = r_cmd.pointer_offset;
                    end
                end else if (r_cmd.request_size == '0) begin
                    do_free = 1'b1;
                end else if (ptr_oob) begin
                    n_out.status = STS_BOUNDS;
                end else if (ptr_dbl) begin
                    n_out.status = STS_DOUBLE;
                end else if (r_cmd.old_size == r_cmd.request_size) begin
                    n_out.result_valid  = 1'b1;
                    n_out.result_offset = r_cmd.pointer_offset;
                end else begin
                    do_alloc = 1'b1;
                    copy_en  = 1'b1;
                end
            end
            default: ;
        endcase

        if (do_alloc) begin
            if (!alloc_fit) begin
                n_out.status = STS_NOSPACE;
            end else if (full) begin
                n_out.status = STS_FULL;
            end else begin
                push                = exec_go;
                n_last              = r_top;
                n_top               = alloc_end[OFS_W-1:0];
                n_count             = r_count + CntW'(1);
                n_out.result_valid  = 1'b1;
                n_out.result_offset = data_off;
                n_out.copy_length   = copy_en ? min_sz : '0;
            end
        end

        if (do_free) begin
            if (ptr_oob) begin
                n_out.status = STS_BOUNDS;
            end else if (ptr_dbl) begin
                n_out.status = STS_DOUBLE;
            end else if (r_count == '0 || r_cmd.pointer_offset != rd_hdr.data) begin
                n_out.status = STS_ORDER;
            end else begin
                n_top   = rd_hdr.prev;
                n_last  = rd_hdr.prev;
                n_count = r_count - CntW'(1);
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_last      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_go) begin
                r_top       <= n_top;
                r_last      <= n_last;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_len  <= OFS_W'(BUF_BYTES);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_LOW: r_base <= i_cfg_data[6:0];
                CFG_BUF_LEN:  r_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_in;
            r_pad <= pad_c;
        end
        if (exec_go) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
